[design/eis_pkg.sv]
// ----------------------------------------------------------------------------
// eis_pkg
// Shared types and constants for the exclusion index selector: row geometry,
// result status codes, sequencer states and the scan control word.
// ----------------------------------------------------------------------------
`default_nettype none

package eis_pkg;

    // Row geometry.
    localparam int MAX_POSITIONS = 64;
    localparam int POS_W         = $clog2(MAX_POSITIONS);
    localparam int CNT_W         = $clog2(MAX_POSITIONS + 1);

    // Field widths of the data words.
    localparam int HEIGHT_W = 8;
    localparam int LEVEL_W  = 7;
    localparam int IDX_W    = 6;
    localparam int STAT_W   = 2;
    localparam int PROFIT_W = CNT_W + 1;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        ST_FOUND    = 2'd0,
        ST_NONE     = 2'd1,
        ST_NEGATIVE = 2'd2,
        ST_BALANCED = 2'd3
    } t_status;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN
    } t_state;

    // Control word that travels alongside one memory read.
    typedef struct packed {
        logic               dv;       // read data is part of a scan
        logic               first;    // first position of a level (highest index)
        logic               lastpos;  // position 0, closes the level
        logic               final_lv; // level is the last one of the run
        logic [LEVEL_W-1:0] level;
        logic [POS_W-1:0]   idx;
    } t_scan_ctl;

endpackage

`default_nettype wire

[design/eis_row_mem.sv]
// ----------------------------------------------------------------------------
// eis_row_mem
// Row storage: one write port for loading positions and one registered read
// port for the backward scan. Each entry holds a height and a source flag.
// ----------------------------------------------------------------------------
`default_nettype none

module eis_row_mem
    import eis_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_we,
    input  wire logic [POS_W-1:0]      i_waddr,
    input  wire logic [HEIGHT_W:0]     i_wdata,
    input  wire logic [POS_W-1:0]      i_raddr,
    output logic      [HEIGHT_W:0]     o_rdata
);

    logic [HEIGHT_W:0] mem [MAX_POSITIONS];
    logic [HEIGHT_W:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[design/eis_profit_unit.sv]
// ----------------------------------------------------------------------------
// eis_profit_unit
// Shared profit counter and compare unit. It consumes one stored position per
// cycle during a scan, tracks the chosen index of the current level and drives
// the registered result word, including the status-only results.
// ----------------------------------------------------------------------------
`default_nettype none

module eis_profit_unit
    import eis_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_scan_ctl                  i_ctl,
    input  wire logic signed [HEIGHT_W-1:0] i_height,
    input  wire logic                       i_source,
    input  wire logic                       i_stat_req,
    input  wire t_status                    i_stat_code,
    output logic                            o_strobe,
    output logic [STAT_W-1:0]               o_status,
    output logic [LEVEL_W-1:0]              o_level,
    output logic [IDX_W-1:0]                o_excluded_index,
    output logic                            o_last_result
);

    logic signed [PROFIT_W-1:0] r_profit, n_profit;
    logic                       r_found, n_found;
    logic [POS_W-1:0]           r_chosen, n_chosen;

    logic                       r_strobe, n_strobe;
    t_status                    r_status, n_status;
    logic [LEVEL_W-1:0]         r_level, n_level;
    logic [IDX_W-1:0]           r_index, n_index;
    logic                       r_last, n_last;

    logic signed [PROFIT_W-1:0] profit_base;
    logic signed [PROFIT_W-1:0] profit_step;
    logic signed [HEIGHT_W-1:0] level_s;
    logic                       at_least;
    logic                       at_level;
    logic                       hit;

    // One scan step: compare the height with the level and move the counter.
    always_comb begin
        level_s     = $signed(HEIGHT_W'(i_ctl.level));
        at_least    = (i_height >= level_s);
        at_level    = (i_height == level_s);
        profit_base = i_ctl.first ? '0 : r_profit;
        profit_step = at_least ? (profit_base + PROFIT_W'(1))
                               : (profit_base - PROFIT_W'(1));
        hit         = at_level && i_source && (profit_step > 0);

        n_profit = r_profit;
        n_found  = r_found;
        n_chosen = r_chosen;
        if (i_ctl.dv) begin
            n_profit = hit ? '0 : profit_step;
            n_found  = (i_ctl.first ? 1'b0 : r_found) | hit;
            n_chosen = hit ? i_ctl.idx : (i_ctl.first ? '0 : r_chosen);
        end
    end

    // Result word: a level closes at position 0, or a status-only result.
    always_comb begin
        n_strobe = 1'b0;
        n_status = r_status;
        n_level  = r_level;
        n_index  = r_index;
        n_last   = r_last;
        if (i_ctl.dv && i_ctl.lastpos) begin
            n_strobe = 1'b1;
            n_status = n_found ? ST_FOUND : ST_NONE;
            n_level  = i_ctl.level;
            n_index  = n_found ? IDX_W'(n_chosen) : '0;
            n_last   = i_ctl.final_lv;
        end else if (i_stat_req) begin
            n_strobe = 1'b1;
            n_status = i_stat_code;
            n_level  = '0;
            n_index  = '0;
            n_last   = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= n_strobe;
        end
    end

    // Scan and result payload registers.
    always_ff @(posedge i_clk) begin
        r_profit <= n_profit;
        r_found  <= n_found;
        r_chosen <= n_chosen;
        r_status <= n_status;
        r_level  <= n_level;
        r_index  <= n_index;
        r_last   <= n_last;
    end

    assign o_strobe         = r_strobe;
    assign o_status         = r_status;
    assign o_level          = r_level;
    assign o_excluded_index = r_index;
    assign o_last_result    = r_last;

endmodule

`default_nettype wire

[design/exclusion_index_selector.sv]
// ----------------------------------------------------------------------------
// exclusion_index_selector
// Loads a row of positions and, for each level up to its imbalance (max 64),
// scans the row backward to choose the position to exclude at that level.
// ----------------------------------------------------------------------------
// Positions are taken one word per cycle while busy is low. The word flagged
// as the last of the row starts the run. A negative or zero imbalance gives a
// single status word in the next cycle, and the block stays ready. A positive
// imbalance L (limited to 64) keeps busy high while L levels are scanned and
// in the drain state: the single profit unit reads the n stored positions,
// one per cycle, from the row memory for each level. The result of a level is
// on the outputs for one cycle, marked by o_strobe, after the read of position
// 0 passes the read, control and result registers. The receiver cannot hold
// results off, and the block never holds them back. o_last_result marks the
// final word of a run. Beyond 64 positions, further words that are not last
// are dropped and the last word overwrites the final position.
// ----------------------------------------------------------------------------
`default_nettype none

module exclusion_index_selector
    import eis_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic signed [HEIGHT_W-1:0] i_height,
    input  wire logic                       i_is_source,
    input  wire logic                       i_last_item,
    output logic                            o_strobe,
    output logic [STAT_W-1:0]               o_status,
    output logic [LEVEL_W-1:0]              o_level,
    output logic [IDX_W-1:0]                o_excluded_index,
    output logic                            o_last_result
);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [POS_W-1:0]   r_addr, n_addr;
    logic [POS_W-1:0]   r_top, n_top;
    logic [LEVEL_W-1:0] r_level, n_level;
    logic [LEVEL_W-1:0] r_levels, n_levels;
    t_scan_ctl          r_pipe, n_pipe;

    logic               accept;
    logic               room;
    logic               mem_we;
    logic [POS_W-1:0]   slot;
    logic [POS_W-1:0]   top_pos;
    logic               run_pos;
    logic               level_done;
    logic               run_done;
    logic               stat_req;
    t_status            stat_code;
    logic [HEIGHT_W:0]  rdata;

    // Input handshake and slot selection.
    always_comb begin
        accept  = start && !busy;
        room    = (r_count < CNT_W'(MAX_POSITIONS));
        slot    = room ? r_count[POS_W-1:0] : POS_W'(MAX_POSITIONS - 1);
        top_pos = slot;
        mem_we  = accept && (room || i_last_item);
        run_pos = accept && i_last_item && (i_height > 0);
    end

    // Status-only results for a row that does not need a scan.
    always_comb begin
        stat_req  = accept && i_last_item && (i_height <= 0);
        stat_code = (i_height < 0) ? ST_NEGATIVE : ST_BALANCED;
    end

    // Scan position bookkeeping.
    always_comb begin
        level_done = (r_addr == '0);
        run_done   = level_done && (r_level == r_levels);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (run_pos) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (run_done) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb begin
        busy      = 1'b1;
        n_pipe    = '0;
        case (r_state)
            S_IDLE: begin
                busy = 1'b0;
            end
            S_SCAN: begin
                n_pipe.dv       = 1'b1;
                n_pipe.first    = (r_addr == r_top);
                n_pipe.lastpos  = level_done;
                n_pipe.final_lv = (r_level == r_levels);
                n_pipe.level    = r_level;
                n_pipe.idx      = r_addr;
            end
            S_DRAIN: begin
                busy = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    // Row count, scan address and level counters.
    always_comb begin
        n_count  = r_count;
        n_addr   = r_addr;
        n_top    = r_top;
        n_level  = r_level;
        n_levels = r_levels;
        if (accept) begin
            if (i_last_item) begin
                n_count = '0;
            end else if (room) begin
                n_count = r_count + CNT_W'(1);
            end
        end
        if (run_pos) begin
            n_addr   = top_pos;
            n_top    = top_pos;
            n_level  = LEVEL_W'(1);
            n_levels = (i_height > HEIGHT_W'(MAX_POSITIONS))
                       ? LEVEL_W'(MAX_POSITIONS) : LEVEL_W'(i_height);
        end else if (r_state == S_SCAN) begin
            if (level_done) begin
                n_addr  = r_top;
                n_level = r_level + LEVEL_W'(1);
            end else begin
                n_addr = r_addr - POS_W'(1);
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pipe  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pipe  <= n_pipe;
        end
    end

    // Scan registers.
    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_top    <= n_top;
        r_level  <= n_level;
        r_levels <= n_levels;
    end

    // Row storage.
    eis_row_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (slot),
        .i_wdata ({i_is_source, i_height}),
        .i_raddr (r_addr),
        .o_rdata (rdata)
    );

    // Shared profit unit and result register.
    eis_profit_unit u_profit (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (r_pipe),
        .i_height         ($signed(rdata[HEIGHT_W-1:0])),
        .i_source         (rdata[HEIGHT_W]),
        .i_stat_req       (stat_req),
        .i_stat_code      (stat_code),
        .o_strobe         (o_strobe),
        .o_status         (o_status),
        .o_level          (o_level),
        .o_excluded_index (o_excluded_index),
        .o_last_result    (o_last_result)
    );

endmodule

`default_nettype wire

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// Exclusion index selector testbench
// Sends rows of positions through the start/busy command port and checks
// every result word against a behavioral predictor of the level scan. The
// stimulus is a few hand-picked rows, then random rows of random-walk or
// noise heights with random idle bursts, a long row that overflows the row
// store, and a closing stretch without idling.
// ----------------------------------------------------------------------------

module testbench
    import eis_pkg::*;
();

    // One position as it is sent, with the idle cycles that follow it.
    typedef struct {
        logic signed [HEIGHT_W-1:0] height;
        logic                       source;
        logic                       closes_row;
        int                         rest_after;
    } t_position;

    // One expected result word.
    typedef struct {
        t_status            status;
        logic [LEVEL_W-1:0] level;
        logic [IDX_W-1:0]   index;
        logic               last;
    } t_exclusion;

    bit                          i_clk;
    logic                        i_rst_n          = 1'b0;
    logic                        start            = 1'b0;
    logic signed [HEIGHT_W-1:0]  i_height         = '0;
    logic                        i_is_source      = 1'b0;
    logic                        i_last_item      = 1'b0;
    logic                        busy;
    logic                        o_strobe;
    logic [STAT_W-1:0]           o_status;
    logic [LEVEL_W-1:0]          o_level;
    logic [IDX_W-1:0]            o_excluded_index;
    logic                        o_last_result;

    // Stimulus and scoreboard.
    t_position  row_words[$];
    t_exclusion awaited_exclusions[$];
    t_exclusion oldest;
    t_position  next_word;
    logic       word_taken = 1'b0;
    int         idle_left  = 0;
    bit         idle_bursts;

    // Predictor state: the row as stored so far.
    logic signed [HEIGHT_W-1:0] row_height [MAX_POSITIONS];
    logic                       row_source [MAX_POSITIONS];
    int                         row_fill = 0;

    int mismatch_count   = 0;
    int positions_taken  = 0;
    int rows_closed      = 0;
    int results_checked  = 0;
    int random_sent;

    exclusion_index_selector uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_height        (i_height),
        .i_is_source     (i_is_source),
        .i_last_item     (i_last_item),
        .o_strobe        (o_strobe),
        .o_status        (o_status),
        .o_level         (o_level),
        .o_excluded_index(o_excluded_index),
        .o_last_result   (o_last_result)
    );

    // Clock with a period of 20.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("MISMATCH %s: got %0d, want %0d (t=%0t)", what, got, want, $time);
    endtask

    // Store one position and, when it closes the row, queue the words the
    // level scan must produce.
    task automatic predict_exclusions(input logic signed [HEIGHT_W-1:0] h,
                                      input logic src, input logic closes);
        t_exclusion r;
        int slot;
        int n;
        int imbalance;
        int top;
        int profit;
        int pick;
        bit hit;
        if (row_fill < MAX_POSITIONS) begin
            slot = row_fill;
        end else if (closes) begin
            // A full row keeps its final slot for the closing position.
            slot = MAX_POSITIONS - 1;
        end else begin
            return;
        end
        row_height[slot] = h;
        row_source[slot] = src;
        if (slot == row_fill) row_fill++;
        if (!closes) return;

        n = row_fill;
        row_fill = 0;
        rows_closed++;
        imbalance = row_height[n-1];

        // A row that does not end above zero gets a single status word.
        if (imbalance <= 0) begin
            r.status = (imbalance < 0) ? ST_NEGATIVE : ST_BALANCED;
            r.level  = '0;
            r.index  = '0;
            r.last   = 1'b1;
            awaited_exclusions.push_back(r);
            return;
        end

        top = (imbalance > MAX_POSITIONS) ? MAX_POSITIONS : imbalance;
        for (int lvl = 1; lvl <= top; lvl++) begin
            profit = 0;
            hit    = 1'b0;
            pick   = 0;
            // Backward scan; the lowest qualifying source wins.
            for (int i = n - 1; i >= 0; i--) begin
                profit += (row_height[i] >= lvl) ? 1 : -1;
                if (row_height[i] == lvl && row_source[i] && profit > 0) begin
                    profit = 0;
                    hit    = 1'b1;
                    pick   = i;
                end
            end
            r.status = hit ? ST_FOUND : ST_NONE;
            r.level  = lvl[LEVEL_W-1:0];
            r.index  = pick[IDX_W-1:0];
            r.last   = (lvl == top);
            awaited_exclusions.push_back(r);
        end
    endtask

    task automatic queue_position(input int h, input bit src, input bit closes);
        t_position p;
        p.height     = h[HEIGHT_W-1:0];
        p.source     = src;
        p.closes_row = closes;
        p.rest_after = (idle_bursts && $urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
        row_words.push_back(p);
    endtask

    // Row of running heights: a source usually lifts the height by one and
    // any other position lowers it, with the odd flag flipped as noise.
    task automatic queue_walk_row(input int n, input int lift);
        int  h;
        bit  src;
        h = 0;
        for (int i = 0; i < n; i++) begin
            src = ($urandom_range(0, 99) < lift);
            h   = src ? h + 1 : h - 1;
            if (h > 64) h = 64;
            if (h < -64) h = -64;
            if ($urandom_range(0, 9) == 0) src = !src;
            queue_position(h, src, i == n - 1);
        end
    endtask

    // Row of unrelated heights from -64 to 64.
    task automatic queue_noise_row(input int n);
        for (int i = 0; i < n; i++) begin
            queue_position($urandom_range(0, 128) - 64, $urandom_range(0, 1), i == n - 1);
        end
    endtask

    // Driver: holds a word while busy, then rests for its idle burst.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || word_taken) begin
            if (idle_left > 0) begin
                idle_left <= idle_left - 1;
                start     <= 1'b0;
            end else if (row_words.size() == 0) begin
                start <= 1'b0;
            end else begin
                next_word    = row_words.pop_front();
                i_height    <= next_word.height;
                i_is_source <= next_word.source;
                i_last_item <= next_word.closes_row;
                idle_left   <= next_word.rest_after;
                start       <= 1'b1;
            end
        end
    end

    // Monitor: checks result words and feeds accepted positions to the
    // predictor.
    always @(posedge i_clk) begin
        word_taken <= i_rst_n && start && !busy;
        if (i_rst_n && o_strobe) begin
            if (awaited_exclusions.size() == 0) begin
                report_mismatch("result word with nothing awaited, status", o_status, 0);
            end else begin
                oldest = awaited_exclusions.pop_front();
                results_checked++;
                if (o_status !== oldest.status)
                    report_mismatch("status", o_status, oldest.status);
                if (o_level !== oldest.level)
                    report_mismatch("level", o_level, oldest.level);
                if (o_excluded_index !== oldest.index)
                    report_mismatch("excluded index", o_excluded_index, oldest.index);
                if (o_last_result !== oldest.last)
                    report_mismatch("last result flag", o_last_result, oldest.last);
            end
        end
        if (i_rst_n && start && !busy) begin
            positions_taken++;
            predict_exclusions(i_height, i_is_source, i_last_item);
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int n;
        int pick;

        // Directed rows: extreme heights, negative and balanced rows, a lone
        // position at the top level, found and empty levels.
        idle_bursts = 1'b1;
        queue_position(0, 0, 0);
        queue_position(-64, 1, 1);
        queue_position(64, 0, 0);
        queue_position(0, 0, 1);
        queue_position(64, 1, 1);
        queue_position(1, 1, 0);
        queue_position(2, 1, 0);
        queue_position(1, 0, 0);
        queue_position(2, 1, 0);
        queue_position(3, 1, 0);
        queue_position(2, 0, 1);
        queue_position(3, 0, 0);
        queue_position(4, 0, 0);
        queue_position(3, 0, 1);
        queue_position(-1, 1, 0);
        queue_position(63, 0, 0);
        queue_position(1, 1, 1);
        queue_position(2, 1, 0);
        queue_position(1, 0, 1);

        // Random rows, mostly short well-formed walks.
        random_sent = 0;
        while (random_sent < 60) begin
            idle_bursts = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                n = $urandom_range(2, 10);
                queue_walk_row(n, $urandom_range(40, 85));
            end else if (pick < 93) begin
                n = $urandom_range(1, 6);
                queue_noise_row(n);
            end else begin
                n = $urandom_range(11, 24);
                queue_walk_row(n, 75);
            end
            random_sent += n;
        end

        // One row past the store size: extra positions are dropped and the
        // closing one lands in the final slot.
        idle_bursts = 1'b1;
        queue_walk_row(MAX_POSITIONS + 2, 90);

        // Closing stretch without idling.
        idle_bursts = 1'b0;
        random_sent = 0;
        while (random_sent < 40) begin
            n = $urandom_range(2, 8);
            if ($urandom_range(0, 4) == 0) queue_noise_row(n);
            else queue_walk_row(n, $urandom_range(40, 85));
            random_sent += n;
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every position to be taken and every result to arrive.
        while (row_words.size() != 0 || start || idle_left != 0) @(posedge i_clk);
        while (awaited_exclusions.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        if (awaited_exclusions.size() != 0)
            report_mismatch("result words never delivered", 0, awaited_exclusions.size());
        $display("Run covered %0d rows from %0d accepted positions; %0d result words checked.",
                 rows_closed, positions_taken, results_checked);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #8000000;
        $display("Watchdog expired with %0d result words outstanding.",
                 awaited_exclusions.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
